### rtl/hsvps_pkg.sv
// Shared types and constants for the HSV pixel class segmenter.
package hsvps_pkg;

    // Divider geometry: numerator, denominator and quotient widths
    localparam int DIV_NUM_W = 17;
    localparam int DIV_DEN_W = 9;
    localparam int DIV_QUO_W = 8;

    // Pixel channel width
    localparam int PIX_W = 8;

    // Conversion constants
    localparam logic [7:0] HUE_TOP  = 8'd179;
    localparam logic [7:0] HUE_WRAP = 8'd180;
    localparam int         HUE_K30  = 30;
    localparam int         HUE_K60  = 60;
    localparam int         HUE_K120 = 120;
    localparam int         HUE_K180 = 180;
    localparam int         SAT_K510 = 510;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_HUE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_SAT_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_VAL_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_VAL_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_HUE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_SAT_MIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_VAL_MIN = 3'd6;

    // Register reset values (hue bounds split into low / high bytes)
    localparam logic [7:0] RST_WHITE_HUE_LO  = 8'd0;
    localparam logic [7:0] RST_WHITE_HUE_HI  = 8'd179;
    localparam logic [7:0] RST_WHITE_SAT_MAX = 8'd60;
    localparam logic [7:0] RST_WHITE_VAL_MIN = 8'd170;
    localparam logic [7:0] RST_BLACK_VAL_MAX = 8'd70;
    localparam logic [7:0] RST_GREEN_HUE_LO  = 8'd35;
    localparam logic [7:0] RST_GREEN_HUE_HI  = 8'd95;
    localparam logic [7:0] RST_GREEN_SAT_MIN = 8'd40;
    localparam logic [7:0] RST_GREEN_VAL_MIN = 8'd40;

    // Result class codes
    typedef enum logic [2:0] {
        CLS_EXCLUDED = 3'd0,
        CLS_GREEN    = 3'd1,
        CLS_WHITE    = 3'd2,
        CLS_BLACK    = 3'd3,
        CLS_NOISE    = 3'd4
    } t_pixel_class;

    // One finished result
    typedef struct packed {
        t_pixel_class cls;
        logic [7:0]   hue;
        logic [7:0]   sat;
        logic [7:0]   val;
    } t_result;

endpackage

### rtl/hsvps_divider.sv
// Pipelined restoring divider: one quotient bit per register stage.
module hsvps_divider (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [hsvps_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [hsvps_pkg::DIV_DEN_W-1:0] i_den,
    output logic [hsvps_pkg::DIV_QUO_W-1:0] o_quo
);
    localparam int NW = hsvps_pkg::DIV_NUM_W;
    localparam int DW = hsvps_pkg::DIV_DEN_W;
    localparam int QW = hsvps_pkg::DIV_QUO_W;

    // Per-stage remainder, divisor and partial quotient
    logic [NW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_quo [QW];

    logic [NW-1:0] w_rem_src [QW];
    logic [DW-1:0] w_den_src [QW];
    logic [QW-1:0] w_quo_src [QW];
    logic [NW:0]   w_sh      [QW];
    logic [NW:0]   w_sub     [QW];
    logic [QW-1:0] n_quo     [QW];

    // Stage inputs: the first stage takes the ports, the rest the stage before
    always_comb begin
        w_rem_src[0] = i_num;
        w_den_src[0] = i_den;
        w_quo_src[0] = '0;
        for (int k = 1; k < QW; k++) begin
            w_rem_src[k] = r_rem[k-1];
            w_den_src[k] = r_den[k-1];
            w_quo_src[k] = r_quo[k-1];
        end
    end

    // Trial subtract of the shifted divisor, one quotient bit per stage
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            w_sh[k]  = {{(NW + 1 - DW){1'b0}}, w_den_src[k]} << (QW - 1 - k);
            w_sub[k] = {1'b0, w_rem_src[k]} - w_sh[k];
            n_quo[k] = w_quo_src[k];
            n_quo[k][QW-1-k] = ~w_sub[k][NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW - 1; k++) begin
                r_rem[k] <= w_sub[k][NW] ? w_rem_src[k] : w_sub[k][NW-1:0];
                r_den[k] <= w_den_src[k];
            end
            for (int k = 0; k < QW; k++) begin
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

### rtl/hsv_pixel_class_segmenter.sv
// Top level: BGR to HSV conversion and green / white / black / noise classification.
//
// Accepts one pixel per clock while the output buffer is not full and returns one result
// per pixel, in order. One stage finds max, min and hue sector, one stage forms the
// saturation and hue numerators, and two 8-stage restoring dividers (one quotient bit
// per stage) produce S and H, which are then classified and written into a 2-entry
// output buffer. The input stays ready as long as that buffer is not full, so the whole
// pipeline holds only while the output side stalls. Hue bounds are clamped to 179 when
// written. Configuration registers are written with a handshake that is always ready;
// writes to unknown indexes are dropped.
module hsv_pixel_class_segmenter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Pixel requests
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_pix_blue,
    input  logic [7:0]                       i_pix_green,
    input  logic [7:0]                       i_pix_red,
    input  logic                             i_pixel_allowed,
    // Results
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [2:0]                       o_pixel_class,
    output logic [7:0]                       o_hue_out,
    output logic [7:0]                       o_sat_out,
    output logic [7:0]                       o_val_out,
    // Configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hsvps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hsvps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int QW = hsvps_pkg::DIV_QUO_W;
    localparam int NW = hsvps_pkg::DIV_NUM_W;
    localparam int DW = hsvps_pkg::DIV_DEN_W;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    function automatic logic [7:0] clamp_hue(input logic [7:0] x);
        return (x > hsvps_pkg::HUE_TOP) ? hsvps_pkg::HUE_TOP : x;
    endfunction

    function automatic logic hue_in_window(input logic [7:0] h, input logic [7:0] lo,
                                           input logic [7:0] hi);
        if (lo <= hi) begin
            return (h >= lo) && (h <= hi);
        end
        return (h >= lo) || (h <= hi);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] r_white_hue_lo, r_white_hue_hi, r_white_sat_max, r_white_val_min;
    logic [7:0] r_black_val_max;
    logic [7:0] r_green_hue_lo, r_green_hue_hi, r_green_sat_min, r_green_val_min;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_hue_lo  <= hsvps_pkg::RST_WHITE_HUE_LO;
            r_white_hue_hi  <= hsvps_pkg::RST_WHITE_HUE_HI;
            r_white_sat_max <= hsvps_pkg::RST_WHITE_SAT_MAX;
            r_white_val_min <= hsvps_pkg::RST_WHITE_VAL_MIN;
            r_black_val_max <= hsvps_pkg::RST_BLACK_VAL_MAX;
            r_green_hue_lo  <= hsvps_pkg::RST_GREEN_HUE_LO;
            r_green_hue_hi  <= hsvps_pkg::RST_GREEN_HUE_HI;
            r_green_sat_min <= hsvps_pkg::RST_GREEN_SAT_MIN;
            r_green_val_min <= hsvps_pkg::RST_GREEN_VAL_MIN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hsvps_pkg::CFG_WHITE_HUE: begin
                    r_white_hue_lo <= clamp_hue(i_cfg_data[7:0]);
                    r_white_hue_hi <= clamp_hue(i_cfg_data[15:8]);
                end
                hsvps_pkg::CFG_WHITE_SAT_MAX: r_white_sat_max <= i_cfg_data[7:0];
                hsvps_pkg::CFG_WHITE_VAL_MIN: r_white_val_min <= i_cfg_data[7:0];
                hsvps_pkg::CFG_BLACK_VAL_MAX: r_black_val_max <= i_cfg_data[7:0];
                hsvps_pkg::CFG_GREEN_HUE: begin
                    r_green_hue_lo <= clamp_hue(i_cfg_data[7:0]);
                    r_green_hue_hi <= clamp_hue(i_cfg_data[15:8]);
                end
                hsvps_pkg::CFG_GREEN_SAT_MIN: r_green_sat_min <= i_cfg_data[7:0];
                hsvps_pkg::CFG_GREEN_VAL_MIN: r_green_val_min <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless the output buffer is full
    // ------------------------------------------------------------------
    logic [1:0] r_cnt;
    logic       w_en;

    assign w_en       = (r_cnt != 2'd2);
    assign o_in_ready = w_en;

    // ------------------------------------------------------------------
    // Stage A: max, min, delta and hue sector
    // ------------------------------------------------------------------
    logic [7:0]        w_a_v, w_a_m1, w_a_m;
    logic signed [8:0] w_a_diff;
    t_sector           w_a_sec;

    always_comb begin
        priority if (i_pix_red >= i_pix_green && i_pix_red >= i_pix_blue) begin
            w_a_sec  = SEC_RED;
            w_a_v    = i_pix_red;
            w_a_diff = $signed({1'b0, i_pix_green}) - $signed({1'b0, i_pix_blue});
        end else if (i_pix_green >= i_pix_blue) begin
            w_a_sec  = SEC_GREEN;
            w_a_v    = i_pix_green;
            w_a_diff = $signed({1'b0, i_pix_blue}) - $signed({1'b0, i_pix_red});
        end else begin
            w_a_sec  = SEC_BLUE;
            w_a_v    = i_pix_blue;
            w_a_diff = $signed({1'b0, i_pix_red}) - $signed({1'b0, i_pix_green});
        end
        w_a_m1 = (i_pix_red < i_pix_green) ? i_pix_red : i_pix_green;
        w_a_m  = (w_a_m1 < i_pix_blue) ? w_a_m1 : i_pix_blue;
    end

    logic              r_a_vld;
    logic [7:0]        r_a_v, r_a_d;
    logic signed [8:0] r_a_diff;
    t_sector           r_a_sec;
    logic              r_a_allow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_v     <= w_a_v;
            r_a_d     <= w_a_v - w_a_m;
            r_a_diff  <= w_a_diff;
            r_a_sec   <= w_a_sec;
            r_a_allow <= i_pixel_allowed;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: divider numerators and denominators
    // ------------------------------------------------------------------
    logic signed [17:0] w_b_dx, w_b_diffx, w_b_off, w_b_num, w_b_fix;
    logic [NW-1:0]      w_b_num_s, w_b_num_h;

    always_comb begin
        w_b_dx    = $signed({10'd0, r_a_d});
        w_b_diffx = {{9{r_a_diff[8]}}, r_a_diff};
        unique case (r_a_sec)
            SEC_RED:   w_b_off = '0;
            SEC_GREEN: w_b_off = w_b_dx * 18'(hsvps_pkg::HUE_K60);
            SEC_BLUE:  w_b_off = w_b_dx * 18'(hsvps_pkg::HUE_K120);
            default:   w_b_off = '0;
        endcase
        w_b_num = w_b_off + w_b_diffx * 18'(hsvps_pkg::HUE_K30);
        // Negative hue wraps by a full turn
        w_b_fix = w_b_num[17] ? (w_b_num + w_b_dx * 18'(hsvps_pkg::HUE_K180)) : w_b_num;
        w_b_num_h = {w_b_fix[15:0], 1'b0} + {9'd0, r_a_d};
        w_b_num_s = ({9'd0, r_a_d} * 17'(hsvps_pkg::SAT_K510)) + {9'd0, r_a_v};
    end

    logic          r_b_vld;
    logic [NW-1:0] r_b_num_s, r_b_num_h;
    logic [DW-1:0] r_b_den_s, r_b_den_h;
    logic [7:0]    r_b_v;
    logic          r_b_dz, r_b_allow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_num_s <= w_b_num_s;
            r_b_num_h <= w_b_num_h;
            r_b_den_s <= {r_a_v, 1'b0};
            r_b_den_h <= {r_a_d, 1'b0};
            r_b_v     <= r_a_v;
            r_b_dz    <= (r_a_d == 8'd0);
            r_b_allow <= r_a_allow;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages, with side data carried alongside
    // ------------------------------------------------------------------
    logic [QW-1:0] w_quo_s, w_quo_h;

    hsvps_divider u_div_sat (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_b_num_s),
        .i_den (r_b_den_s),
        .o_quo (w_quo_s)
    );

    hsvps_divider u_div_hue (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_b_num_h),
        .i_den (r_b_den_h),
        .o_quo (w_quo_h)
    );

    logic       r_dl_vld   [QW];
    logic [7:0] r_dl_v     [QW];
    logic       r_dl_dz    [QW];
    logic       r_dl_allow [QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_dl_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_dl_vld[0] <= r_b_vld;
            for (int k = 1; k < QW; k++) begin
                r_dl_vld[k] <= r_dl_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_v[0]     <= r_b_v;
            r_dl_dz[0]    <= r_b_dz;
            r_dl_allow[0] <= r_b_allow;
            for (int k = 1; k < QW; k++) begin
                r_dl_v[k]     <= r_dl_v[k-1];
                r_dl_dz[k]    <= r_dl_dz[k-1];
                r_dl_allow[k] <= r_dl_allow[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Classification
    // ------------------------------------------------------------------
    hsvps_pkg::t_result w_res;
    logic               w_green, w_white, w_black;

    always_comb begin
        w_res.val = r_dl_v[QW-1];
        // Grey pixels get hue 0; a rounded hue of 180 wraps to 0
        w_res.hue = (r_dl_dz[QW-1] || w_quo_h >= hsvps_pkg::HUE_WRAP) ? 8'd0 : w_quo_h;
        w_res.sat = (r_dl_v[QW-1] == 8'd0) ? 8'd0 : w_quo_s;
        w_green = hue_in_window(w_res.hue, r_green_hue_lo, r_green_hue_hi) &&
                  (w_res.sat >= r_green_sat_min) && (w_res.val >= r_green_val_min);
        w_white = hue_in_window(w_res.hue, r_white_hue_lo, r_white_hue_hi) &&
                  (w_res.sat <= r_white_sat_max) && (w_res.val >= r_white_val_min);
        w_black = (w_res.val <= r_black_val_max);
        priority if (!r_dl_allow[QW-1]) begin
            w_res.cls = hsvps_pkg::CLS_EXCLUDED;
        end else if (w_green) begin
            w_res.cls = hsvps_pkg::CLS_GREEN;
        end else if (w_white) begin
            w_res.cls = hsvps_pkg::CLS_WHITE;
        end else if (w_black) begin
            w_res.cls = hsvps_pkg::CLS_BLACK;
        end else begin
            w_res.cls = hsvps_pkg::CLS_NOISE;
        end
    end

    // ------------------------------------------------------------------
    // Two-entry output buffer
    // ------------------------------------------------------------------
    hsvps_pkg::t_result r_fifo [2];
    logic               r_wr_ptr, r_rd_ptr;
    logic               w_fifo_wr, w_fifo_rd;
    hsvps_pkg::t_result w_head;

    assign w_fifo_wr   = w_en && r_dl_vld[QW-1];
    assign o_out_valid = (r_cnt != 2'd0);
    assign w_fifo_rd   = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_fifo_wr} - {1'b0, w_fifo_rd};
            if (w_fifo_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_fifo_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fifo_wr) begin
            r_fifo[r_wr_ptr] <= w_res;
        end
    end

    assign w_head        = r_fifo[r_rd_ptr];
    assign o_pixel_class = w_head.cls;
    assign o_hue_out     = w_head.hue;
    assign o_sat_out     = w_head.sat;
    assign o_val_out     = w_head.val;

`ifndef SYNTHESIS
    // No result may land in a full output buffer
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !w_fifo_wr)
        else $error("result written into full output buffer");

    // Buffer count stays within its two entries
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    // Delivered hue is always folded into 0..179
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hue_out < hsvps_pkg::HUE_WRAP))
        else $error("hue out of range");

    // Zero saturation means a grey pixel, so hue must be zero too
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sat_out == 8'd0) |-> (o_hue_out == 8'd0))
        else $error("grey pixel with nonzero hue");

    // Black pixel yields zero saturation
    a_black_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_val_out == 8'd0) |-> (o_sat_out == 8'd0))
        else $error("zero value with nonzero saturation");
`endif

endmodule

### tb/hsvps_result_checker.sv
// Result checker for the HSV pixel class segmenter: predicts each request and compares.
`timescale 1ns / 100ps

module hsvps_result_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Pixel request channel
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [7:0]                       i_pix_blue,
    input  logic [7:0]                       i_pix_green,
    input  logic [7:0]                       i_pix_red,
    input  logic                             i_pixel_allowed,
    // Result channel
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [2:0]                       i_pixel_class,
    input  logic [7:0]                       i_hue_out,
    input  logic [7:0]                       i_sat_out,
    input  logic [7:0]                       i_val_out,
    // Configuration write channel
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [hsvps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hsvps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Status to the top
    output int                               o_fail_count,
    output int                               o_pending
);

    // Local copy of the threshold registers
    logic [15:0] white_hue_win;
    logic [7:0]  white_sat_max;
    logic [7:0]  white_val_min;
    logic [7:0]  black_val_max;
    logic [15:0] green_hue_win;
    logic [7:0]  green_sat_min;
    logic [7:0]  green_val_min;

    hsvps_pkg::t_result predicted_pixels[$];
    hsvps_pkg::t_result want;
    int                 fail_count = 0;
    int                 result_no  = 0;

    task automatic report_fail(input string msg);
        $display("%0t checker: %s", $time, msg);
        fail_count++;
    endtask

    // Bounds above 179 act as 179; a window with lo > hi wraps through zero
    function automatic bit hue_in_window(input int hue, input logic [15:0] win);
        int lo;
        int hi;
        lo = (win[7:0] > hsvps_pkg::HUE_TOP) ? int'(hsvps_pkg::HUE_TOP) : int'(win[7:0]);
        hi = (win[15:8] > hsvps_pkg::HUE_TOP) ? int'(hsvps_pkg::HUE_TOP) : int'(win[15:8]);
        if (lo <= hi)
            return (hue >= lo) && (hue <= hi);
        return (hue >= lo) || (hue <= hi);
    endfunction

    // BGR -> HSV (180-step hue, round half up), then class by priority
    function automatic hsvps_pkg::t_result classify_pixel(input logic [7:0] blue,
                                                          input logic [7:0] green,
                                                          input logic [7:0] red,
                                                          input logic allowed);
        int                 bi, gi, ri;
        int                 vmax, vmin, d, num, sat, hue;
        bit                 green_hit, white_hit, black_hit;
        hsvps_pkg::t_result res;
        bi   = int'(blue);
        gi   = int'(green);
        ri   = int'(red);
        vmax = ri;
        vmin = ri;
        if (gi > vmax) vmax = gi;
        if (bi > vmax) vmax = bi;
        if (gi < vmin) vmin = gi;
        if (bi < vmin) vmin = bi;
        d    = vmax - vmin;
        sat  = (vmax > 0) ? (510 * d + vmax) / (2 * vmax) : 0;
        hue  = 0;
        if (d > 0) begin
            // red sector wins ties, then green
            if (vmax == ri)
                num = 30 * (gi - bi);
            else if (vmax == gi)
                num = 60 * d + 30 * (bi - ri);
            else
                num = 120 * d + 30 * (ri - gi);
            if (num < 0)
                num += 180 * d;
            hue = (2 * num + d) / (2 * d);
            if (hue >= 180)
                hue = 0;
        end
        green_hit = hue_in_window(hue, green_hue_win) && sat >= green_sat_min &&
                    vmax >= green_val_min;
        white_hit = hue_in_window(hue, white_hue_win) && sat <= white_sat_max &&
                    vmax >= white_val_min;
        black_hit = vmax <= black_val_max;
        if (!allowed)
            res.cls = hsvps_pkg::CLS_EXCLUDED;
        else if (green_hit)
            res.cls = hsvps_pkg::CLS_GREEN;
        else if (white_hit)
            res.cls = hsvps_pkg::CLS_WHITE;
        else if (black_hit)
            res.cls = hsvps_pkg::CLS_BLACK;
        else
            res.cls = hsvps_pkg::CLS_NOISE;
        res.hue = hue[7:0];
        res.sat = sat[7:0];
        res.val = vmax[7:0];
        return res;
    endfunction

    // Track requests, results and register writes at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            white_hue_win = {hsvps_pkg::RST_WHITE_HUE_HI, hsvps_pkg::RST_WHITE_HUE_LO};
            white_sat_max = hsvps_pkg::RST_WHITE_SAT_MAX;
            white_val_min = hsvps_pkg::RST_WHITE_VAL_MIN;
            black_val_max = hsvps_pkg::RST_BLACK_VAL_MAX;
            green_hue_win = {hsvps_pkg::RST_GREEN_HUE_HI, hsvps_pkg::RST_GREEN_HUE_LO};
            green_sat_min = hsvps_pkg::RST_GREEN_SAT_MIN;
            green_val_min = hsvps_pkg::RST_GREEN_VAL_MIN;
            predicted_pixels.delete();
        end else begin
            // Result side: compare with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (predicted_pixels.size() == 0) begin
                    report_fail($sformatf("unexpected result: class %0d hue %0d sat %0d val %0d",
                                          i_pixel_class, i_hue_out, i_sat_out, i_val_out));
                end else begin
                    want = predicted_pixels.pop_front();
                    if (i_pixel_class !== want.cls)
                        report_fail($sformatf("result %0d class: expected %0d got %0d",
                                              result_no, want.cls, i_pixel_class));
                    if (i_hue_out !== want.hue)
                        report_fail($sformatf("result %0d hue: expected %0d got %0d",
                                              result_no, want.hue, i_hue_out));
                    if (i_sat_out !== want.sat)
                        report_fail($sformatf("result %0d sat: expected %0d got %0d",
                                              result_no, want.sat, i_sat_out));
                    if (i_val_out !== want.val)
                        report_fail($sformatf("result %0d val: expected %0d got %0d",
                                              result_no, want.val, i_val_out));
                end
                result_no++;
            end
            // Request side
            if (i_in_valid && i_in_ready)
                predicted_pixels.push_back(classify_pixel(i_pix_blue, i_pix_green, i_pix_red,
                                                          i_pixel_allowed));
            // Register writes; unknown indexes drop
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    hsvps_pkg::CFG_WHITE_HUE:     white_hue_win = i_cfg_data;
                    hsvps_pkg::CFG_WHITE_SAT_MAX: white_sat_max = i_cfg_data[7:0];
                    hsvps_pkg::CFG_WHITE_VAL_MIN: white_val_min = i_cfg_data[7:0];
                    hsvps_pkg::CFG_BLACK_VAL_MAX: black_val_max = i_cfg_data[7:0];
                    hsvps_pkg::CFG_GREEN_HUE:     green_hue_win = i_cfg_data;
                    hsvps_pkg::CFG_GREEN_SAT_MIN: green_sat_min = i_cfg_data[7:0];
                    hsvps_pkg::CFG_GREEN_VAL_MIN: green_val_min = i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= predicted_pixels.size();
        o_fail_count <= fail_count;
    end

endmodule

### tb/tb_top.sv
// Testbench top for the HSV pixel class segmenter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int PHASE_ITEMS    = 120;
    localparam int RX_HOLD_CYCLES = 64;
    localparam int DRAIN_CYCLES   = 24;
    localparam int STALL_LIMIT    = 2000;

    // Index with no register behind it
    localparam logic [hsvps_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    // One full set of register write words
    typedef struct {
        logic [hsvps_pkg::CFG_DATA_W-1:0] white_hue;
        logic [hsvps_pkg::CFG_DATA_W-1:0] white_sat_max;
        logic [hsvps_pkg::CFG_DATA_W-1:0] white_val_min;
        logic [hsvps_pkg::CFG_DATA_W-1:0] black_val_max;
        logic [hsvps_pkg::CFG_DATA_W-1:0] green_hue;
        logic [hsvps_pkg::CFG_DATA_W-1:0] green_sat_min;
        logic [hsvps_pkg::CFG_DATA_W-1:0] green_val_min;
    } t_seg_cfg;

    logic                             i_clk           = 1'b0;
    logic                             i_rst_n         = 1'b0;
    logic                             i_in_valid      = 1'b0;
    logic [7:0]                       i_pix_blue      = '0;
    logic [7:0]                       i_pix_green     = '0;
    logic [7:0]                       i_pix_red       = '0;
    logic                             i_pixel_allowed = 1'b0;
    logic                             i_out_ready     = 1'b0;
    logic                             i_cfg_valid     = 1'b0;
    logic [hsvps_pkg::CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [hsvps_pkg::CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                             o_in_ready;
    logic                             o_out_valid;
    logic [2:0]                       o_pixel_class;
    logic [7:0]                       o_hue_out;
    logic [7:0]                       o_sat_out;
    logic [7:0]                       o_val_out;
    logic                             o_cfg_ready;

    int  fail_total;
    int  results_pending;
    int  quiet_cycles = 0;
    bit  tx_idle_en   = 1'b0;
    bit  rx_idle_en   = 1'b0;
    bit  rx_hold_req  = 1'b0;
    bit  rx_hold_done = 1'b0;

    hsv_pixel_class_segmenter i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pix_blue      (i_pix_blue),
        .i_pix_green     (i_pix_green),
        .i_pix_red       (i_pix_red),
        .i_pixel_allowed (i_pixel_allowed),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_class   (o_pixel_class),
        .o_hue_out       (o_hue_out),
        .o_sat_out       (o_sat_out),
        .o_val_out       (o_val_out),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    hsvps_result_checker u_result_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_pix_blue      (i_pix_blue),
        .i_pix_green     (i_pix_green),
        .i_pix_red       (i_pix_red),
        .i_pixel_allowed (i_pixel_allowed),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_pixel_class   (o_pixel_class),
        .i_hue_out       (o_hue_out),
        .i_sat_out       (o_sat_out),
        .i_val_out       (o_val_out),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_total),
        .o_pending       (results_pending)
    );

    // 100 MHz clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("** hsv_pixel_class_segmenter: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result sink: random back-pressure bursts, plus one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req && !rx_hold_done) begin
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_done = 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // One register write; valid stays up for back-to-back writes
    task automatic write_reg(input logic [hsvps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hsvps_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Write every register, then poke the unused index
    task automatic apply_settings(input t_seg_cfg c);
        write_reg(hsvps_pkg::CFG_WHITE_HUE,     c.white_hue);
        write_reg(hsvps_pkg::CFG_WHITE_SAT_MAX, c.white_sat_max);
        write_reg(hsvps_pkg::CFG_WHITE_VAL_MIN, c.white_val_min);
        write_reg(hsvps_pkg::CFG_BLACK_VAL_MAX, c.black_val_max);
        write_reg(hsvps_pkg::CFG_GREEN_HUE,     c.green_hue);
        write_reg(hsvps_pkg::CFG_GREEN_SAT_MIN, c.green_sat_min);
        write_reg(hsvps_pkg::CFG_GREEN_VAL_MIN, c.green_val_min);
        write_reg(CFG_NO_REG,                   16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Hue window: plain, wrapped, out-of-range bytes, or narrow
    function automatic logic [15:0] random_hue_window();
        logic [7:0] lo;
        logic [7:0] hi;
        case ($urandom_range(0, 3))
            0: begin
                lo = 8'($urandom_range(0, 179));
                hi = 8'($urandom_range(179, lo));
            end
            1: begin
                lo = 8'($urandom_range(1, 179));
                hi = 8'($urandom_range(0, lo - 1));
            end
            2: begin
                lo = 8'($urandom);
                hi = 8'($urandom);
            end
            default: begin
                lo = 8'($urandom_range(0, 170));
                hi = 8'(lo + $urandom_range(0, 9));
            end
        endcase
        return {hi, lo};
    endfunction

    function automatic t_seg_cfg random_settings();
        t_seg_cfg c;
        c.white_hue     = random_hue_window();
        c.white_sat_max = 16'($urandom);
        c.white_val_min = 16'($urandom);
        c.black_val_max = 16'($urandom);
        c.green_hue     = random_hue_window();
        c.green_sat_min = 16'($urandom);
        c.green_val_min = 16'($urandom);
        return c;
    endfunction

    // Offer one pixel request, optionally after an idle burst
    task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                              input logic [7:0] red, input logic allowed);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_pix_blue      <= blue;
        i_pix_green     <= green;
        i_pix_red       <= red;
        i_pixel_allowed <= allowed;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Random pixels: uniform, near-grey, extreme codes and tied channels
    task automatic run_random_phase(input int count);
        logic [7:0] blue, green, red;
        int         base;
        repeat (count) begin
            blue  = 8'($urandom);
            green = 8'($urandom);
            red   = 8'($urandom);
            case ($urandom_range(0, 9))
                5, 6: begin
                    base  = int'($urandom_range(3, 252));
                    blue  = 8'(base + $urandom_range(0, 6) - 3);
                    green = 8'(base + $urandom_range(0, 6) - 3);
                    red   = 8'(base + $urandom_range(0, 6) - 3);
                end
                7: begin
                    blue  = ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(0, 1));
                    green = ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(0, 1));
                    red   = ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(0, 1));
                end
                8: begin
                    case ($urandom_range(0, 2))
                        0:       green = red;
                        1:       blue  = green;
                        default: red   = blue;
                    endcase
                end
                default: ;
            endcase
            send_pixel(blue, green, red, $urandom_range(0, 7) != 0);
        end
    endtask

    // Hold off new requests until every predicted result is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
    endtask

    // Main stimulus
    initial begin
        t_seg_cfg plan;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels under reset thresholds
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
        send_pixel(8'd0,   8'd0,   8'd0,   1'b1);   // V of zero
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);   // grey, bright white
        send_pixel(8'd128, 8'd128, 8'd128, 1'b1);   // grey, mid level
        send_pixel(8'd0,   8'd0,   8'd255, 1'b1);   // pure red
        send_pixel(8'd0,   8'd255, 8'd0,   1'b1);   // pure green
        send_pixel(8'd255, 8'd0,   8'd0,   1'b1);   // pure blue
        send_pixel(8'd1,   8'd0,   8'd255, 1'b1);   // hue rounds to 180, wraps
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);   // masked out
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);   // masked out, black
        send_pixel(8'd0,   8'd0,   8'd1,   1'b1);   // smallest nonzero V
        send_pixel(8'd200, 8'd210, 8'd220, 1'b1);   // whitish
        send_pixel(8'd10,  8'd50,  8'd10,  1'b1);   // dark green
        send_pixel(8'd70,  8'd70,  8'd70,  1'b1);   // black edge
        send_pixel(8'd71,  8'd71,  8'd71,  1'b1);   // just above black
        send_pixel(8'd0,   8'd255, 8'd255, 1'b1);   // red and green tie
        send_pixel(8'd255, 8'd255, 8'd0,   1'b1);   // green and blue tie
        send_pixel(8'd255, 8'd0,   8'd255, 1'b1);   // red and blue tie
        wait_drained();

        // All-zero thresholds
        plan = '{default: '0};
        apply_settings(plan);
        run_random_phase(PHASE_ITEMS);
        wait_drained();

        // All-ones: every hue bound saturates
        plan = '{default: 16'hFFFF};
        apply_settings(plan);
        run_random_phase(PHASE_ITEMS);
        wait_drained();

        // Wrapped windows, sender flat out against one long output hold
        plan = '{white_hue: {8'd10, 8'd170}, white_sat_max: 16'd90, white_val_min: 16'd100,
                 black_val_max: 16'd50, green_hue: {8'd20, 8'd200}, green_sat_min: 16'd30,
                 green_val_min: 16'd30};
        apply_settings(plan);
        tx_idle_en = 1'b0;
        rx_hold_req <= 1'b1;
        send_pixel(8'd10,  8'd0,   8'd255, 1'b1);
        send_pixel(8'd0,   8'd20,  8'd255, 1'b1);
        send_pixel(8'd250, 8'd250, 8'd255, 1'b1);
        send_pixel(8'd200, 8'd180, 8'd40,  1'b1);
        run_random_phase(PHASE_ITEMS);
        wait_drained();
        tx_idle_en = 1'b1;

        // Random settings
        repeat (5) begin
            plan = random_settings();
            apply_settings(plan);
            run_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        // Closing stretch at full rate on both sides
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        plan = random_settings();
        apply_settings(plan);
        run_random_phase(PHASE_ITEMS);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_total == 0)
            $display("** hsv_pixel_class_segmenter: PASSED **");
        else
            $display("** hsv_pixel_class_segmenter: FAILED **");
        $finish;
    end

endmodule
